FILE: src/i2ctpm_pkg.sv
// Shared types and codes for the I2C target packet mailbox.
package i2ctpm_pkg;

    // One bus line change: which line, its new level, the other line's level
    typedef struct packed {
        logic req_type;
        logic new_level;
        logic other_level;
    } in_item_t;

    // Line drive after the change and the packet check outcome
    typedef struct packed {
        logic       sda_release;
        logic [1:0] packet_status;
    } out_item_t;

    // Line that changed
    localparam logic REQ_SCL = 1'b0;
    localparam logic REQ_SDA = 1'b1;

    // Packet check outcomes
    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_VALID   = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd3;

    localparam int ADDR_BITS = 7;
    localparam int BYTE_BITS = 8;

    // Bus phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ADDR = 4'b0010,
        PH_RX   = 4'b0100,
        PH_TX   = 4'b1000
    } bus_phase_t;

    // Acknowledge sequencing across clock falls: drive, then release
    typedef enum logic [2:0] {
        ACK_NONE   = 3'b001,
        ACK_START  = 3'b010,
        ACK_FINISH = 3'b100
    } ack_phase_t;

endpackage

FILE: src/i2ctpm_ram.sv
// Generic single-port-write, registered-read RAM.
module i2ctpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, register the read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/i2ctpm_core.sv
// Bus protocol engine: start/stop, byte shifting, acknowledge, packet check and reply.
module i2ctpm_core
    import i2ctpm_pkg::*;
#(
    parameter int PACKET_BYTES     = 24,
    parameter int REPLY_DATA_BYTES = 19
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  in_item_t             item,
    input  logic [ADDR_BITS-1:0] own_address,
    output out_item_t            result
);

    localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int CW = $clog2(PACKET_BYTES + 2);
    localparam int TW = $clog2(PACKET_BYTES + 1);

    localparam logic [CW-1:0] RX_FULL = CW'(PACKET_BYTES);
    localparam logic [CW-1:0] RX_OVER = CW'(PACKET_BYTES + 1);
    localparam logic [TW-1:0] TX_END  = TW'(PACKET_BYTES);
    localparam logic [TW-1:0] TX_LAST = TW'(PACKET_BYTES - 1);
    localparam logic [TW-1:0] TX_LEN  = TW'(3);
    localparam logic [BYTE_BITS-1:0] REPLY_LEN = BYTE_BITS'(REPLY_DATA_BYTES);
    localparam logic [BYTE_BITS-1:0] REPLY_SUM = BYTE_BITS'(256 - REPLY_DATA_BYTES);

    bus_phase_t           bus_phase_reg, bus_phase_next;
    ack_phase_t           ack_phase_reg, ack_phase_next;
    logic                 ack_pos_reg, ack_pos_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic [3:0]           bit_count_reg, bit_count_next;
    logic [CW-1:0]        rx_count_reg, rx_count_next;
    logic [BYTE_BITS-1:0] sum_reg, sum_next;
    logic [TW-1:0]        tx_index_reg, tx_index_next;
    logic                 reply_pending_reg, reply_pending_next;
    logic                 reply_ready_reg, reply_ready_next;
    logic                 sda_reg, sda_next;
    logic [1:0]           status;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [TW-1:0]        rd_index;
    logic [BYTE_BITS-1:0] rd_data;
    logic [BYTE_BITS-1:0] tx_byte;
    logic [CW-1:0]        stored_count;
    logic [2:0]           bit_pos;
    logic                 nacked;

    // Packet buffer
    i2ctpm_ram #(
        .WIDTH(BYTE_BITS),
        .DEPTH(PACKET_BYTES)
    ) u_buffer (
        .aclk   (aclk),
        .wr_en  (wr_en & step),
        .wr_addr(wr_addr),
        .wr_data(shift_next),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Work out the state after one line change, in bus event order
    always_comb begin
        bus_phase_next     = bus_phase_reg;
        ack_phase_next     = ack_phase_reg;
        ack_pos_next       = ack_pos_reg;
        shift_next         = shift_reg;
        bit_count_next     = bit_count_reg;
        rx_count_next      = rx_count_reg;
        sum_next           = sum_reg;
        tx_index_next      = tx_index_reg;
        reply_pending_next = reply_pending_reg;
        reply_ready_next   = reply_ready_reg;
        sda_next           = sda_reg;
        status             = STATUS_NONE;
        wr_en              = 1'b0;
        wr_addr            = rx_count_reg[AW-1:0];
        tx_byte            = '0;
        stored_count       = '0;
        bit_pos            = '0;
        nacked             = 1'b0;

        if (item.req_type == REQ_SDA) begin
            // Data change with clock high: start or stop
            if (item.other_level && !item.new_level) begin
                bus_phase_next = PH_ADDR;
                shift_next     = '0;
                bit_count_next = '0;
            end else if (item.other_level && item.new_level) begin
                bus_phase_next = PH_IDLE;
            end
        end else begin
            // Clock rise: shift in one bit
            if (item.new_level && (bus_phase_reg == PH_ADDR || bus_phase_reg == PH_RX) &&
                ack_phase_reg == ACK_NONE) begin
                shift_next = {shift_reg[BYTE_BITS-2:0], item.other_level};
                if (bit_count_reg != 4'd15) begin
                    bit_count_next = bit_count_reg + 4'd1;
                end
                if (bit_count_next == 4'd8) begin
                    ack_phase_next = ACK_START;
                    ack_pos_next   = 1'b1;
                    if (bus_phase_reg == PH_ADDR) begin
                        if (shift_next[BYTE_BITS-1:1] != own_address) begin
                            ack_pos_next   = 1'b0;
                            bus_phase_next = PH_IDLE;
                        end else if (!shift_next[0]) begin
                            rx_count_next      = '0;
                            sum_next           = '0;
                            reply_ready_next   = 1'b0;
                            shift_next         = '0;
                            bit_count_next     = '0;
                            bus_phase_next     = PH_RX;
                            reply_pending_next = 1'b1;
                        end else begin
                            if (reply_pending_reg) begin
                                if (rx_count_reg != RX_FULL) begin
                                    status = STATUS_BAD_LEN;
                                end else if (sum_reg != '0) begin
                                    status = STATUS_BAD_SUM;
                                end else begin
                                    status           = STATUS_VALID;
                                    reply_ready_next = 1'b1;
                                end
                                reply_pending_next = 1'b0;
                            end
                            bus_phase_next = PH_TX;
                            tx_index_next  = '0;
                            bit_count_next = '0;
                        end
                    end else begin
                        // Store the received byte while the buffer has room and fold it into the sum
                        wr_en = (rx_count_reg < RX_FULL);
                        sum_next = sum_reg + shift_next;
                        if (rx_count_reg < RX_OVER) begin
                            rx_count_next = rx_count_reg + 1'b1;
                        end
                        bit_count_next = '0;
                    end
                end
            end

            // Clock fall: drive and release the acknowledge
            if (!item.new_level && ack_phase_next == ACK_START) begin
                sda_next       = !ack_pos_next;
                ack_phase_next = ACK_FINISH;
            end else if (!item.new_level && ack_phase_next == ACK_FINISH) begin
                sda_next       = 1'b1;
                ack_phase_next = ACK_NONE;
            end

            // Clock fall: shift out one bit unless the master refused the byte
            if (!item.new_level && bus_phase_next == PH_TX && ack_phase_next == ACK_NONE) begin
                nacked = (tx_index_next != '0) && (bit_count_next == '0) && item.other_level;
                if (!nacked) begin
                    if (reply_ready_next) begin
                        stored_count = RX_FULL;
                    end else if (rx_count_next < RX_FULL) begin
                        stored_count = rx_count_next;
                    end else begin
                        stored_count = RX_FULL;
                    end
                    if (CW'(tx_index_next) >= stored_count) begin
                        tx_byte = '0;
                    end else if (reply_ready_next) begin
                        if (tx_index_next == TX_LAST) begin
                            tx_byte = REPLY_SUM;
                        end else if (tx_index_next == TX_LEN) begin
                            tx_byte = REPLY_LEN;
                        end else begin
                            tx_byte = '0;
                        end
                    end else begin
                        tx_byte = rd_data;
                    end
                    bit_pos = (bit_count_next < 4'd8) ? 3'(4'd7 - bit_count_next) : 3'd0;
                    sda_next = tx_byte[bit_pos];
                    bit_count_next = bit_count_next + 4'd1;
                    if (bit_count_next >= 4'd8) begin
                        ack_phase_next = ACK_START;
                        ack_pos_next   = 1'b0;
                        bit_count_next = '0;
                        if (tx_index_next < TX_END) begin
                            tx_index_next = tx_index_next + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Keep the buffer read address on the current transmit index
    assign rd_index = step ? tx_index_next : tx_index_reg;
    assign rd_addr  = (rd_index < TX_END) ? rd_index[AW-1:0] : '0;

    // Advance the state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_phase_reg     <= PH_IDLE;
            ack_phase_reg     <= ACK_NONE;
            ack_pos_reg       <= 1'b0;
            shift_reg         <= '0;
            bit_count_reg     <= '0;
            rx_count_reg      <= '0;
            sum_reg           <= '0;
            tx_index_reg      <= '0;
            reply_pending_reg <= 1'b0;
            reply_ready_reg   <= 1'b0;
            sda_reg           <= 1'b1;
        end else if (step) begin
            bus_phase_reg     <= bus_phase_next;
            ack_phase_reg     <= ack_phase_next;
            ack_pos_reg       <= ack_pos_next;
            shift_reg         <= shift_next;
            bit_count_reg     <= bit_count_next;
            rx_count_reg      <= rx_count_next;
            sum_reg           <= sum_next;
            tx_index_reg      <= tx_index_next;
            reply_pending_reg <= reply_pending_next;
            reply_ready_reg   <= reply_ready_next;
            sda_reg           <= sda_next;
        end
    end

    assign result.sda_release   = sda_next;
    assign result.packet_status = status;

    // A checked packet never stays pending
    a_ready_not_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        reply_ready_reg |-> !reply_pending_reg)
        else $error("reply ready while still pending");

    // A reply is built only on entry to transmit
    a_reply_in_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(reply_ready_reg) |-> bus_phase_reg == PH_TX)
        else $error("reply armed outside transmit");

    // Counters stay within their saturation limits
    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= RX_OVER && tx_index_reg <= TX_END)
        else $error("byte counter past limit");

    // A passed check is reported only with a good length and sum
    a_valid_status: assert property (@(posedge aclk) disable iff (!aresetn)
        step && status == STATUS_VALID |-> rx_count_reg == RX_FULL && sum_reg == '0)
        else $error("valid status on a bad packet");

endmodule

FILE: src/i2c_target_packet_mailbox.sv
// Top level of the I2C target packet mailbox: handshakes, address register, result register.
// A result is registered and appears on m_ in the cycle after its bus event transaction is accepted.
// Throughput: one event per cycle while s_ready is high; all work for an event is done by the core's
//   combinational step between its state registers and the result register.
// s_ready drops only while a result waits in the output register and m_ready is low.
// Reset (aresetn, synchronous, active low) idles the bus engine, releases SDA,
//   clears own_address and empties the output register; the packet buffer is not cleared.
module i2c_target_packet_mailbox
    import i2ctpm_pkg::*;
#(
    parameter int PACKET_BYTES     = 24,
    parameter int REPLY_DATA_BYTES = 19
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ADDR_BITS-1:0] cfg_data
);

    logic [ADDR_BITS-1:0] own_address_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;
    out_item_t            core_result;
    logic                 s_accept;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Protocol engine
    i2ctpm_core #(
        .PACKET_BYTES    (PACKET_BYTES),
        .REPLY_DATA_BYTES(REPLY_DATA_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (s_accept),
        .item       (s_data),
        .own_address(own_address_reg),
        .result     (core_result)
    );

    // Hold the bus address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            own_address_reg <= cfg_data;
        end
    end

    // Load or drain the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= core_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
